/* hdl/assert_macros.svh */
// Assertion macros shared by the frame checker RTL.
// Define NO_ASSERTIONS to compile every use to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked property, switched off while reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked property that must hold in reset too.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* hdl/mfc_pkg.sv */
// ----------------------------------------------------------------------------
// mfc_pkg: shared types and constants of the message frame checker
// Event codes, register indexes, queue payload structs and the checksum step.
// ----------------------------------------------------------------------------
`default_nettype none

package mfc_pkg;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_HEADER   = 3'd1;
    localparam logic [2:0] EV_PAYLOAD  = 3'd2;
    localparam logic [2:0] EV_OK       = 3'd3;
    localparam logic [2:0] EV_VERSION  = 3'd4;
    localparam logic [2:0] EV_CHECKSUM = 3'd5;
    localparam logic [2:0] EV_LENGTH   = 3'd6;

    localparam int unsigned ADDR_W = 4;
    localparam logic [1:0] REG_MAGIC   = 2'd0;
    localparam logic [1:0] REG_VERSION = 2'd1;
    localparam logic [1:0] REG_MAX_LEN = 2'd2;

    localparam logic [7:0] DIGEST_BIAS = 8'h11;

    // One received byte with its checksum digest, as the front hands it on.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic [7:0] digest;
    } t_byte_item;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  payload_byte;
        logic [15:0] message_id;
        logic [15:0] payload_length;
        logic        last;
    } t_result;

    // Byte rotated right by three, plus bias, modulo 256.
    function automatic logic [7:0] mfc_digest(input logic [7:0] b);
        return {b[2:0], b[7:3]} + DIGEST_BIAS;
    endfunction

    // Rotate the sum left by a byte and fold in the digest.
    function automatic logic [31:0] mfc_sum_step(input logic [31:0] sum,
                                                 input logic [7:0]  d);
        return {sum[23:0], sum[31:24]} ^ {24'd0, d};
    endfunction

endpackage

`default_nettype wire

/* hdl/message_frame_checker_unit.sv */
// ----------------------------------------------------------------------------
// message_frame_checker_unit: framed message receiver with checksum
// Finds magic-framed messages in a byte stream, passes payload bytes on and
// reports header, version, length and checksum outcomes, one result per byte.
//
//   channel   direction  handshake           payload
//   rx        in         i_push / o_full     i_rx_byte
//   result    out        o_empty / i_pop     o_event_res .. o_last
//   config    in         psel/penable/pready paddr, pwdata, prdata
//
// One byte per cycle sustained unless the result queue is full; the
// sequencer retires one byte per cycle but stalls on a full result queue.
// A byte's result passes the byte queue, then the result queue, to the ports.
// Reset (i_rst_n low, synchronous) empties both queues and restarts hunting.
// The input side stalls only when the byte queue is full, which happens once
// the result queue is full and not popped.
// ----------------------------------------------------------------------------
`default_nettype none

module message_frame_checker_unit
    import mfc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [7:0]        i_rx_byte,
    output logic                   o_full,
    output logic                   o_empty,
    input  wire logic              i_pop,
    output logic [2:0]             o_event_res,
    output logic [7:0]             o_payload_byte,
    output logic [15:0]            o_message_id,
    output logic [15:0]            o_payload_length,
    output logic                   o_last,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [15:0] r_magic;
    logic [15:0] r_version;
    logic [15:0] r_max_len;
    logic [1:0]  reg_idx;
    logic        cfg_write;

    logic        mid_full, mid_empty, mid_push, mid_pop;
    t_byte_item  mid_in, mid_out;
    logic        out_full, out_push;
    t_result     out_in, out_res;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic   <= 16'd0;
            r_version <= 16'd0;
            r_max_len <= 16'hFFFF;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_MAGIC:   r_magic   <= pwdata[15:0];
                REG_VERSION: r_version <= pwdata[15:0];
                REG_MAX_LEN: r_max_len <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MAGIC:   prdata = {16'd0, r_magic};
            REG_VERSION: prdata = {16'd0, r_version};
            REG_MAX_LEN: prdata = {16'd0, r_max_len};
            default:     prdata = 32'd0;
        endcase
    end

    mfc_front u_front (
        .i_push    (i_push),
        .i_rx_byte (i_rx_byte),
        .o_full    (o_full),
        .i_q_full  (mid_full),
        .o_q_push  (mid_push),
        .o_q_item  (mid_in)
    );

    mfc_queue #(
        .WIDTH ($bits(t_byte_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (mid_in),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_data  (mid_out),
        .o_empty (mid_empty)
    );

    mfc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_magic   (r_magic),
        .i_cfg_version (r_version),
        .i_cfg_max_len (r_max_len),
        .i_in_valid    (!mid_empty),
        .i_in_item     (mid_out),
        .o_in_pop      (mid_pop),
        .i_out_full    (out_full),
        .o_out_push    (out_push),
        .o_out_res     (out_in)
    );

    mfc_queue #(
        .WIDTH ($bits(t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_in),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_data  (out_res),
        .o_empty (o_empty)
    );

    assign o_event_res      = out_res.event_res;
    assign o_payload_byte   = out_res.payload_byte;
    assign o_message_id     = out_res.message_id;
    assign o_payload_length = out_res.payload_length;
    assign o_last           = out_res.last;

endmodule

`default_nettype wire

/* hdl/mfc_queue.sv */
// ----------------------------------------------------------------------------
// mfc_queue: small first-in first-out queue
// Register-file queue with push/full and pop/empty sides; DEPTH a power of two.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mfc_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + PW'(1) : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + PW'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `ASSERT_CLK(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "queue count over depth")
    `ASSERT_CLK(a_grow, i_clk, i_rst_n, (do_push && !do_pop) |=> (r_count == $past(r_count) + CW'(1)), "queue did not grow on push")
    `ASSERT_CLK(a_shrink, i_clk, i_rst_n, (do_pop && !do_push) |=> (r_count == $past(r_count) - CW'(1)), "queue did not shrink on pop")

endmodule

`default_nettype wire

/* hdl/mfc_front.sv */
// ----------------------------------------------------------------------------
// mfc_front: byte intake
// Takes received bytes, works out the checksum digest and queues both.
// ----------------------------------------------------------------------------
`default_nettype none

module mfc_front
    import mfc_pkg::*;
(
    input  wire logic       i_push,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_full,
    input  wire logic       i_q_full,
    output logic            o_q_push,
    output t_byte_item      o_q_item
);

    assign o_full           = i_q_full;
    assign o_q_push         = i_push && !i_q_full;
    assign o_q_item.rx_byte = i_rx_byte;
    assign o_q_item.digest  = mfc_digest(i_rx_byte);

endmodule

`default_nettype wire

/* hdl/mfc_back.sv */
// ----------------------------------------------------------------------------
// mfc_back: frame sequencer
// Hunts for the magic word, parses the header, checks version, length and
// checksum, and emits one result for every byte.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mfc_back
    import mfc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [15:0] i_cfg_magic,
    input  wire logic [15:0] i_cfg_version,
    input  wire logic [15:0] i_cfg_max_len,
    input  wire logic        i_in_valid,
    input  wire t_byte_item  i_in_item,
    output logic             o_in_pop,
    input  wire logic        i_out_full,
    output logic             o_out_push,
    output t_result          o_out_res
);

    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_FOOTER  = 2'd3;

    logic [1:0]  r_phase, n_phase;
    logic [7:0]  r_prev, n_prev;
    logic        r_have_prev, n_have_prev;
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_version, n_version;
    logic [15:0] r_id, n_id;
    logic [15:0] r_length, n_length;
    logic [31:0] r_sum, n_sum;
    logic [31:0] r_rx_sum, n_rx_sum;

    logic        fire;
    logic [7:0]  b;
    logic [7:0]  d;
    logic [15:0] pos_inc;
    logic [2:0]  ev;
    logic [7:0]  pb;
    logic        lst;

    assign fire     = i_in_valid && !i_out_full;
    assign o_in_pop = fire;
    assign b        = i_in_item.rx_byte;
    assign d        = i_in_item.digest;
    assign pos_inc  = r_pos + 16'd1;

    always_comb begin
        n_phase     = r_phase;
        n_prev      = r_prev;
        n_have_prev = r_have_prev;
        n_pos       = r_pos;
        n_version   = r_version;
        n_id        = r_id;
        n_length    = r_length;
        n_sum       = r_sum;
        n_rx_sum    = r_rx_sum;
        ev          = EV_NONE;
        pb          = 8'd0;
        lst         = 1'b0;

        unique case (r_phase)
            PH_HEADER: begin
                n_sum = mfc_sum_step(r_sum, d);
                unique case (r_pos[2:1])
                    2'd0: begin
                        if (r_pos[0]) n_version[15:8] = b;
                        else          n_version[7:0]  = b;
                    end
                    2'd1: begin
                        if (r_pos[0]) n_id[15:8] = b;
                        else          n_id[7:0]  = b;
                    end
                    default: begin
                        if (r_pos[0]) n_length[15:8] = b;
                        else          n_length[7:0]  = b;
                    end
                endcase
                n_pos = pos_inc;
                if (pos_inc == 16'd2 && n_version != i_cfg_version) begin
                    ev          = EV_VERSION;
                    lst         = 1'b1;
                    n_phase     = PH_HUNT;
                    n_have_prev = 1'b0;
                    n_pos       = 16'd0;
                end else if (pos_inc == 16'd6) begin
                    if (n_length > i_cfg_max_len) begin
                        ev          = EV_LENGTH;
                        lst         = 1'b1;
                        n_phase     = PH_HUNT;
                        n_have_prev = 1'b0;
                        n_pos       = 16'd0;
                    end else begin
                        ev       = EV_HEADER;
                        n_pos    = 16'd0;
                        n_rx_sum = 32'd0;
                        n_phase  = (n_length == 16'd0) ? PH_FOOTER : PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_sum = mfc_sum_step(r_sum, d);
                ev    = EV_PAYLOAD;
                pb    = b;
                n_pos = pos_inc;
                if (pos_inc >= r_length) begin
                    n_pos   = 16'd0;
                    n_phase = PH_FOOTER;
                end
            end
            PH_FOOTER: begin
                n_rx_sum[{r_pos[1:0], 3'b000} +: 8] = b;
                n_pos = pos_inc;
                if (pos_inc >= 16'd4) begin
                    ev          = (n_rx_sum == r_sum) ? EV_OK : EV_CHECKSUM;
                    lst         = 1'b1;
                    n_phase     = PH_HUNT;
                    n_have_prev = 1'b0;
                    n_pos       = 16'd0;
                end
            end
            default: begin
                if (r_have_prev && {b, r_prev} == i_cfg_magic) begin
                    // both magic bytes count towards the sum
                    n_sum       = {16'd0, mfc_digest(r_prev), d};
                    n_version   = 16'd0;
                    n_id        = 16'd0;
                    n_length    = 16'd0;
                    n_rx_sum    = 32'd0;
                    n_pos       = 16'd0;
                    n_have_prev = 1'b0;
                    n_phase     = PH_HEADER;
                end else begin
                    n_prev      = b;
                    n_have_prev = 1'b1;
                    n_phase     = PH_HUNT;
                end
            end
        endcase
    end

    assign o_out_push                = fire;
    assign o_out_res.event_res       = ev;
    assign o_out_res.payload_byte    = pb;
    assign o_out_res.message_id      = n_id;
    assign o_out_res.payload_length  = n_length;
    assign o_out_res.last            = lst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_prev      <= 8'd0;
            r_have_prev <= 1'b0;
            r_pos       <= 16'd0;
            r_version   <= 16'd0;
            r_id        <= 16'd0;
            r_length    <= 16'd0;
            r_sum       <= 32'd0;
            r_rx_sum    <= 32'd0;
        end else if (fire) begin
            r_phase     <= n_phase;
            r_prev      <= n_prev;
            r_have_prev <= n_have_prev;
            r_pos       <= n_pos;
            r_version   <= n_version;
            r_id        <= n_id;
            r_length    <= n_length;
            r_sum       <= n_sum;
            r_rx_sum    <= n_rx_sum;
        end
    end

    `ASSERT_CLK(a_payload_len, i_clk, i_rst_n, (r_phase == PH_PAYLOAD) |-> (r_length != 16'd0), "payload phase with zero length")
    `ASSERT_CLK(a_prev_only_hunt, i_clk, i_rst_n, (r_phase != PH_HUNT) |-> !r_have_prev, "window byte held outside hunt")
    `ASSERT_CLK(a_last_event, i_clk, i_rst_n, (fire && lst) |-> (ev == EV_OK || ev == EV_VERSION || ev == EV_CHECKSUM || ev == EV_LENGTH), "frame end without end event")
    `ASSERT_CLK(a_footer_pos, i_clk, i_rst_n, (r_phase == PH_FOOTER) |-> (r_pos < 16'd4), "footer position out of range")

endmodule

`default_nettype wire
